// File: rtl/tlu_pkg.sv
// Shared types and constants for the two-way cache tag lookup.
// Holds the config register codes, reset values and the per-set state row.
// No dependencies.
package tlu_pkg;

    localparam int ADDR_W     = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int IDX_BITS_W = 4;

    localparam int DEF_MAX_SETS         = 512;
    localparam int DEF_LINE_OFFSET_BITS = 4;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LRU_MODE   = 1'd1;

    localparam logic [IDX_BITS_W-1:0] RST_INDEX_BITS = 4'd9;
    localparam logic                  RST_LRU_MODE   = 1'b1;

    // per-set replacement state: valid bit of each way and the victim way
    typedef struct packed {
        logic v1;
        logic v0;
        logic victim;
    } t_set_st;

    // after reset: both ways empty, way 1 filled first
    localparam t_set_st ST_CLEAR = '{v1: 1'b0, v0: 1'b0, victim: 1'b1};

endpackage

// File: rtl/tlu_cfg_regs.sv
// Configuration registers of the tag lookup: set index width and policy.
// Depends on tlu_pkg.
module tlu_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tlu_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tlu_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic [tlu_pkg::IDX_BITS_W-1:0]    o_index_bits,
    output logic                              o_lru_mode
);

    logic [tlu_pkg::IDX_BITS_W-1:0] r_index_bits;
    logic                           r_lru_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits <= tlu_pkg::RST_INDEX_BITS;
            r_lru_mode   <= tlu_pkg::RST_LRU_MODE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tlu_pkg::CFG_INDEX_BITS: begin
                    r_index_bits <= i_cfg_data[tlu_pkg::IDX_BITS_W-1:0];
                end
                tlu_pkg::CFG_LRU_MODE: begin
                    r_lru_mode <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_index_bits = r_index_bits;
    assign o_lru_mode   = r_lru_mode;

endmodule

// File: rtl/tlu_clear_seq.sv
// Post-reset sweep over the set state memory, one set per cycle.
// Depends on nothing but its parameter.
module tlu_clear_seq #(
    parameter int MAX_SETS = 512
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    output logic                         o_active,
    output logic [$clog2(MAX_SETS)-1:0]  o_idx
);

    localparam int SET_W = $clog2(MAX_SETS);
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);

    logic             r_active;
    logic             n_active;
    logic [SET_W-1:0] r_idx;
    logic [SET_W-1:0] n_idx;

    always_comb begin
        n_active = r_active;
        n_idx    = r_idx;
        if (r_active) begin
            n_idx = r_idx + SET_W'(1);
            if (r_idx == LAST_SET) begin
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b1;
            r_idx    <= '0;
        end else begin
            r_active <= n_active;
            r_idx    <= n_idx;
        end
    end

    assign o_active = r_active;
    assign o_idx    = r_idx;

endmodule

// File: rtl/tlu_lookup.sv
// Lookup datapath: memory read stage, tag compare/update stage, result register.
// Holds the tag memory and the set state memory. Depends on tlu_pkg.
module tlu_lookup #(
    parameter int MAX_SETS         = 512,
    parameter int LINE_OFFSET_BITS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_acc,
    input  logic [tlu_pkg::ADDR_W-1:0]          i_address,
    input  logic [tlu_pkg::IDX_BITS_W-1:0]      i_index_bits,
    input  logic                                i_lru_mode,
    input  logic                                i_clr_active,
    input  logic [$clog2(MAX_SETS)-1:0]         i_clr_idx,
    output logic                                o_valid,
    output logic                                o_hit,
    output logic                                o_way_used
);

    localparam int SET_W  = $clog2(MAX_SETS);
    localparam int TAG_W  = tlu_pkg::ADDR_W - LINE_OFFSET_BITS;
    localparam int MAX_IB = $clog2(MAX_SETS + 1) - 1;   // floor(log2(MAX_SETS))

    typedef logic [1:0][TAG_W-1:0] t_tag_row;

    t_tag_row          r_tag_mem [MAX_SETS];
    tlu_pkg::t_set_st  r_st_mem  [MAX_SETS];

    logic [TAG_W-1:0]  line;
    logic [SET_W-1:0]  set_mask;
    logic [SET_W-1:0]  set_idx;

    // stage 1
    logic              r_s1_vld;
    logic [TAG_W-1:0]  r_s1_line;
    logic [SET_W-1:0]  r_s1_set;
    logic              r_s1_lru;
    t_tag_row          r_tag_rd;
    tlu_pkg::t_set_st  r_st_rd;

    // copy of the last write, for a request to the same set right behind it
    logic              r_wb_st_vld;
    logic              r_wb_tag_vld;
    logic [SET_W-1:0]  r_wb_set;
    t_tag_row          r_wb_tag_row;
    tlu_pkg::t_set_st  r_wb_st_row;

    t_tag_row          tag_row;
    tlu_pkg::t_set_st  st_row;
    logic              hit0;
    logic              hit1;
    logic              hit;
    logic              way;
    t_tag_row          n_tag_row;
    tlu_pkg::t_set_st  n_st_row;

    logic              r_o_vld;
    logic              r_o_hit;
    logic              r_o_way;

    // stage 0: line number and set select
    assign line = i_address[tlu_pkg::ADDR_W-1:LINE_OFFSET_BITS];

    // index_bits above log2(MAX_SETS) saturates
    for (genvar g = 0; g < SET_W; g++) begin : g_mask
        assign set_mask[g] = (g < MAX_IB) && (5'(g) < {1'b0, i_index_bits});
    end

    assign set_idx = line[SET_W-1:0] & set_mask;

    always_ff @(posedge i_clk) begin
        r_tag_rd <= r_tag_mem[set_idx];
        r_st_rd  <= r_st_mem[set_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_line <= line;
            r_s1_set  <= set_idx;
            r_s1_lru  <= i_lru_mode;
        end
    end

    // stage 1: compare and update
    assign tag_row = (r_wb_tag_vld && (r_wb_set == r_s1_set)) ? r_wb_tag_row : r_tag_rd;
    assign st_row  = (r_wb_st_vld && (r_wb_set == r_s1_set)) ? r_wb_st_row : r_st_rd;

    assign hit0 = st_row.v0 && (tag_row[0] == r_s1_line);
    assign hit1 = st_row.v1 && (tag_row[1] == r_s1_line);
    assign hit  = hit0 || hit1;
    assign way  = hit0 ? 1'b0 : (hit1 ? 1'b1 : st_row.victim);

    always_comb begin
        n_tag_row = tag_row;
        n_st_row  = st_row;
        if (hit) begin
            if (r_s1_lru) begin
                n_st_row.victim = ~way;
            end
        end else begin
            n_tag_row[way]  = r_s1_line;
            n_st_row.victim = ~way;
            if (way) begin
                n_st_row.v1 = 1'b1;
            end else begin
                n_st_row.v0 = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clr_active) begin
            r_st_mem[i_clr_idx] <= tlu_pkg::ST_CLEAR;
        end else if (r_s1_vld) begin
            r_st_mem[r_s1_set] <= n_st_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld && !hit) begin
            r_tag_mem[r_s1_set] <= n_tag_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_st_vld  <= 1'b0;
            r_wb_tag_vld <= 1'b0;
        end else begin
            r_wb_st_vld  <= r_s1_vld;
            r_wb_tag_vld <= r_s1_vld && !hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_set     <= r_s1_set;
        r_wb_tag_row <= n_tag_row;
        r_wb_st_row  <= n_st_row;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_hit <= hit;
        r_o_way <= way;
    end

    assign o_valid    = r_o_vld;
    assign o_hit      = r_o_hit;
    assign o_way_used = r_o_way;

    // every accepted request gives a result on o_valid, through r_s1_vld and then r_o_vld
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc |=> ##1 o_valid)
        else $error("accepted request produced no result");

    // no request is taken while the set state memory is being cleared
    a_no_acc_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clr_active |-> !i_acc && !r_s1_vld)
        else $error("request in flight during clear sweep");

    // a line is never held in both ways of one set
    a_no_double_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> !(hit0 && hit1))
        else $error("line present in both ways");

    // a miss always leaves a valid bit set in the forwarded state row of that set
    a_fill_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !hit) |=> r_wb_tag_vld && (r_wb_st_row.v0 || r_wb_st_row.v1))
        else $error("fill did not set a valid bit");

endmodule

// File: rtl/two_way_cache_tag_lookup.sv
// Two-way set-associative tag lookup, 16-byte lines by default. One request
// (a byte address) is taken per cycle when start is high and busy is low. The
// set memories are read on the request edge, and the tag compare and update run
// in the following cycle into the result register. The result (hit, way used)
// is therefore on the outputs with o_valid once the result register is loaded,
// for one cycle. It cannot be held off. A request to the set written just
// before it gets that write forwarded, so back-to-back requests never stall.
// After reset busy stays high while the set state memory (valid and victim
// bits) is swept clear, one set per cycle; config writes are taken during
// that time.
// Depends on tlu_pkg, tlu_cfg_regs, tlu_clear_seq, tlu_lookup.
module two_way_cache_tag_lookup #(
    parameter int MAX_SETS         = tlu_pkg::DEF_MAX_SETS,
    parameter int LINE_OFFSET_BITS = tlu_pkg::DEF_LINE_OFFSET_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [tlu_pkg::ADDR_W-1:0]        i_address,
    input  logic                              i_cfg_we,
    input  logic [tlu_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tlu_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_valid,
    output logic                              o_hit,
    output logic                              o_way_used
);

    localparam int SET_W = $clog2(MAX_SETS);

    logic [tlu_pkg::IDX_BITS_W-1:0] index_bits;
    logic                           lru_mode;
    logic                           clr_active;
    logic [SET_W-1:0]               clr_idx;
    logic                           acc;

    tlu_cfg_regs u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_index_bits (index_bits),
        .o_lru_mode   (lru_mode)
    );

    tlu_clear_seq #(
        .MAX_SETS (MAX_SETS)
    ) u_clr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .o_active (clr_active),
        .o_idx    (clr_idx)
    );

    assign busy = clr_active;
    assign acc  = start && !clr_active;

    tlu_lookup #(
        .MAX_SETS         (MAX_SETS),
        .LINE_OFFSET_BITS (LINE_OFFSET_BITS)
    ) u_lookup (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (acc),
        .i_address    (i_address),
        .i_index_bits (index_bits),
        .i_lru_mode   (lru_mode),
        .i_clr_active (clr_active),
        .i_clr_idx    (clr_idx),
        .o_valid      (o_valid),
        .o_hit        (o_hit),
        .o_way_used   (o_way_used)
    );

endmodule
